@@ design/assert_macros.svh @@
// Assertion macros used by the ring buffer back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ design/brb_pkg.sv @@
// Types and constants of the byte ring buffer.
package brb_pkg;

    localparam int CAPACITY    = 1024;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int PTR_W       = IDX_W + 1;
    localparam int MAX_REQUEST = 64;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int FILL_W = 11;

    // Queue depths are powers of two so that the pointers wrap on their own.
    localparam int JQ_DEPTH = 2;
    localparam int JQ_IDX_W = $clog2(JQ_DEPTH);
    localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_IDX_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PRODUCE = 2'd0,
        CMD_CONSUME = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_DROP    = 2'd3
    } t_cmd;

    typedef enum logic {
        B_IDLE,
        B_READ
    } t_bstate;

    typedef struct packed {
        t_cmd              cmd;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } t_job;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              byte_valid;
        logic [LEN_W-1:0]  moved;
        logic [FILL_W-1:0] fill;
        logic              last;
    } t_result;

endpackage

@@ design/brb_front.sv @@
// Front end: decodes input beats into jobs and holds them in a short queue.
module brb_front
    import brb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [1:0]        i_command,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [LEN_W-1:0]  i_length,
    output logic              o_job_valid,
    output t_job              o_job,
    input  logic              i_job_pop
);

    t_job                r_jq [JQ_DEPTH];
    logic [JQ_IDX_W-1:0] r_head;
    logic [JQ_IDX_W-1:0] r_tail;
    logic [JQ_CNT_W-1:0] r_cnt;
    logic [JQ_IDX_W-1:0] n_head;
    logic [JQ_IDX_W-1:0] n_tail;
    logic [JQ_CNT_W-1:0] n_cnt;
    logic                enq;
    logic                deq;
    t_job                job_in;

    always_comb begin
        job_in.cmd  = t_cmd'(i_command);
        job_in.data = i_data_byte;
        if (i_length > LEN_W'(MAX_REQUEST)) begin
            job_in.len = LEN_W'(MAX_REQUEST);
        end else begin
            job_in.len = i_length;
        end
    end

    assign o_full      = (r_cnt == JQ_CNT_W'(JQ_DEPTH));
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_jq[r_head];
    assign enq         = i_push && !o_full;
    assign deq         = i_job_pop && o_job_valid;

    always_comb begin
        n_head = deq ? r_head + 1'b1 : r_head;
        n_tail = enq ? r_tail + 1'b1 : r_tail;
        n_cnt  = r_cnt + JQ_CNT_W'(enq) - JQ_CNT_W'(deq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_jq[r_tail] <= job_in;
        end
    end

endmodule

@@ design/brb_back.sv @@
// Back end: ring pointers, byte store and the sequencer that executes jobs.
`include "assert_macros.svh"

module brb_back
    import brb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  t_job                i_job,
    output logic                o_job_pop,
    input  logic [OQ_CNT_W-1:0] i_q_count,
    output logic                o_res_push,
    output t_result             o_res
);

    logic [BYTE_W-1:0] r_store [CAPACITY];
    logic [BYTE_W-1:0] r_rdata;

    t_bstate           r_state;
    t_bstate           n_state;
    logic [PTR_W-1:0]  r_rptr;
    logic [PTR_W-1:0]  n_rptr;
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  n_wptr;
    logic [PTR_W-1:0]  r_addr;
    logic [PTR_W-1:0]  n_addr;
    logic [LEN_W-1:0]  r_left;
    logic [LEN_W-1:0]  n_left;
    logic [LEN_W-1:0]  r_moved;
    logic [LEN_W-1:0]  n_moved;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;

    logic              r_s_valid;
    logic              n_s_valid;
    logic              r_s_mem;
    logic              n_s_mem;
    t_result           r_s_res;
    t_result           n_s_res;

    logic [PTR_W-1:0]  ring_fill;
    logic [PTR_W-1:0]  len_ext;
    logic [PTR_W-1:0]  take;
    logic [PTR_W-1:0]  fill_after;
    logic              can_issue;
    logic              mem_we;
    logic              mem_re;
    logic [IDX_W-1:0]  raddr;

    assign ring_fill = r_wptr - r_rptr;
    assign len_ext   = PTR_W'(i_job.len);
    assign take      = (len_ext < ring_fill) ? len_ext : ring_fill;
    assign can_issue = (({1'b0, i_q_count} + (OQ_CNT_W + 1)'(r_s_valid))
                        < (OQ_CNT_W + 1)'(OQ_DEPTH));
    assign fill_after = (i_job.cmd == CMD_CONSUME) ? ring_fill - take : ring_fill;

    always_comb begin
        n_state   = r_state;
        n_rptr    = r_rptr;
        n_wptr    = r_wptr;
        n_addr    = r_addr;
        n_left    = r_left;
        n_moved   = r_moved;
        n_fill    = r_fill;
        n_s_valid = 1'b0;
        n_s_mem   = 1'b0;
        n_s_res   = r_s_res;
        o_job_pop = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        raddr     = r_addr[IDX_W-1:0];

        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid && can_issue) begin
                    o_job_pop          = 1'b1;
                    n_s_valid          = 1'b1;
                    n_s_res.read_byte  = '0;
                    n_s_res.byte_valid = 1'b0;
                    n_s_res.moved      = '0;
                    n_s_res.fill       = FILL_W'(ring_fill);
                    n_s_res.last       = 1'b1;
                    unique case (i_job.cmd) inside
                        CMD_PRODUCE: begin
                            if (ring_fill < PTR_W'(CAPACITY)) begin
                                mem_we        = 1'b1;
                                n_wptr        = r_wptr + 1'b1;
                                n_s_res.moved = LEN_W'(1);
                                n_s_res.fill  = FILL_W'(ring_fill + 1'b1);
                            end
                        end
                        CMD_DROP: begin
                            n_rptr        = r_rptr + take;
                            n_s_res.moved = LEN_W'(take);
                            n_s_res.fill  = FILL_W'(ring_fill - take);
                        end
                        CMD_CONSUME, CMD_PEEK: begin
                            if (take != '0) begin
                                mem_re             = 1'b1;
                                raddr              = r_rptr[IDX_W-1:0];
                                n_s_mem            = 1'b1;
                                n_s_res.byte_valid = 1'b1;
                                n_s_res.moved      = LEN_W'(take);
                                n_s_res.fill       = FILL_W'(fill_after);
                                n_s_res.last       = (take == PTR_W'(1));
                                n_addr             = r_rptr + 1'b1;
                                n_left             = LEN_W'(take - 1'b1);
                                n_moved            = LEN_W'(take);
                                n_fill             = FILL_W'(fill_after);
                                if (i_job.cmd == CMD_CONSUME) begin
                                    n_rptr = r_rptr + take;
                                end
                                if (take != PTR_W'(1)) begin
                                    n_state = B_READ;
                                end
                            end
                        end
                        default: begin
                            n_s_res.moved = '0;
                        end
                    endcase
                end
            end
            B_READ: begin
                if (can_issue) begin
                    mem_re             = 1'b1;
                    n_s_valid          = 1'b1;
                    n_s_mem            = 1'b1;
                    n_s_res.read_byte  = '0;
                    n_s_res.byte_valid = 1'b1;
                    n_s_res.moved      = r_moved;
                    n_s_res.fill       = r_fill;
                    n_s_res.last       = (r_left == LEN_W'(1));
                    n_addr             = r_addr + 1'b1;
                    n_left             = r_left - 1'b1;
                    if (r_left == LEN_W'(1)) begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_rptr    <= '0;
            r_wptr    <= '0;
            r_left    <= '0;
            r_s_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rptr    <= n_rptr;
            r_wptr    <= n_wptr;
            r_left    <= n_left;
            r_s_valid <= n_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_moved <= n_moved;
        r_fill  <= n_fill;
        r_s_mem <= n_s_mem;
        r_s_res <= n_s_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_wptr[IDX_W-1:0]] <= i_job.data;
        end
        if (mem_re) begin
            r_rdata <= r_store[raddr];
        end
    end

    always_comb begin
        o_res_push = r_s_valid;
        o_res      = r_s_res;
        if (r_s_mem) begin
            o_res.read_byte = r_rdata;
        end
    end

    `ASSERT_NEVER(a_fill_range, i_clk, i_rst_n, ring_fill > PTR_W'(CAPACITY))
    `ASSERT_IMPLY(a_read_left, i_clk, i_rst_n, r_state == B_READ, r_left != '0)
    `ASSERT_NEVER(a_port_conflict, i_clk, i_rst_n, mem_we && mem_re)
    `ASSERT_IMPLY(a_queue_room, i_clk, i_rst_n, r_s_valid, i_q_count < OQ_CNT_W'(OQ_DEPTH))

endmodule

@@ design/brb_outq.sv @@
// Result queue that holds finished beats until the receiver pops them.
module brb_outq
    import brb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_result             i_res,
    input  logic                i_pop,
    output logic                o_empty,
    output t_result             o_res,
    output logic [OQ_CNT_W-1:0] o_count
);

    t_result             r_q [OQ_DEPTH];
    logic [OQ_IDX_W-1:0] r_head;
    logic [OQ_IDX_W-1:0] r_tail;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic [OQ_IDX_W-1:0] n_head;
    logic [OQ_IDX_W-1:0] n_tail;
    logic [OQ_CNT_W-1:0] n_cnt;
    logic                deq;

    assign o_empty = (r_cnt == '0);
    assign o_res   = r_q[r_head];
    assign o_count = r_cnt;
    assign deq     = i_pop && !o_empty;

    always_comb begin
        n_head = deq ? r_head + 1'b1 : r_head;
        n_tail = i_push ? r_tail + 1'b1 : r_tail;
        n_cnt  = r_cnt + OQ_CNT_W'(i_push) - OQ_CNT_W'(deq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_tail] <= i_res;
        end
    end

endmodule

@@ design/byte_ring_buffer_top.sv @@
// Top level of the byte ring buffer: front end, back end and result queue.
//
// Input beats carry a command (produce, consume, peek, drop), a data byte and
// a length; a beat is taken when push is high and full is low. Result beats
// come out oldest first while empty is low and leave when pop is high.
// Produce and drop give one result beat each. Consume and peek give one beat
// per byte moved, with last on the final one, or a single beat with a zero
// count when nothing moves. Every beat reports the fill level after the
// command. A command passes the job queue, the back end result register and
// the result queue in turn. Produce and drop run at one beat per cycle while
// the result queue has room; consume or peek of n bytes makes n store reads,
// one per cycle through the single read port while the queue has room.
// Reset clears the pointers and both queues, not the store itself. When the
// receiver stalls, the four-entry result queue fills, the back end stops,
// the two-entry job queue fills and full rises.
module byte_ring_buffer_top
    import brb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_command,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [LEN_W-1:0]  i_length,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] o_read_byte,
    output logic              o_byte_valid,
    output logic [LEN_W-1:0]  o_moved_count,
    output logic [FILL_W-1:0] o_fill_level,
    output logic              o_last
);

    logic                job_valid;
    t_job                job;
    logic                job_pop;
    logic [OQ_CNT_W-1:0] q_count;
    logic                res_push;
    t_result             res_in;
    t_result             res_out;

    brb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_length    (i_length),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    brb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .i_q_count   (q_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    brb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (res_out),
        .o_count (q_count)
    );

    assign o_read_byte   = res_out.read_byte;
    assign o_byte_valid  = res_out.byte_valid;
    assign o_moved_count = res_out.moved;
    assign o_fill_level  = res_out.fill;
    assign o_last        = res_out.last;

endmodule

@@ dv/tb_byte_ring_buffer_top.sv @@
// Self-checking testbench for the byte ring buffer top level.
`timescale 1ns / 100ps

module tb_byte_ring_buffer_top;
    import brb_pkg::*;

    localparam int LIMIT = 3_000_000;

    typedef struct {
        t_cmd              cmd;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        bit                typed;
        logic [LEN_W-1:0]  moved;
        logic [FILL_W-1:0] fill;
    } t_dir_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              push        = 1'b0;
    logic              pop         = 1'b0;
    logic [1:0]        i_command   = '0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic [LEN_W-1:0]  i_length    = '0;
    logic              full;
    logic              empty;
    logic [BYTE_W-1:0] o_read_byte;
    logic              o_byte_valid;
    logic [LEN_W-1:0]  o_moved_count;
    logic [FILL_W-1:0] o_fill_level;
    logic              o_last;

    logic [BYTE_W-1:0] ring_store [CAPACITY];
    logic [PTR_W-1:0]  ring_rd = '0;
    logic [PTR_W-1:0]  ring_wr = '0;
    t_result           pending_beats [$];
    t_result           want_beat;
    int                mismatches = 0;
    int                cycles     = 0;
    int                stall_left = 0;
    bit                quiet      = 1'b0;

    t_dir_row dir_rows [23] = '{
        '{CMD_CONSUME, 8'h00, 7'd5,   1'b1, 7'd0, 11'd0},
        '{CMD_PEEK,    8'hFF, 7'd0,   1'b1, 7'd0, 11'd0},
        '{CMD_DROP,    8'h00, 7'd127, 1'b1, 7'd0, 11'd0},
        '{CMD_PRODUCE, 8'h00, 7'd0,   1'b1, 7'd1, 11'd1},
        '{CMD_PRODUCE, 8'hFF, 7'd127, 1'b1, 7'd1, 11'd2},
        '{CMD_PRODUCE, 8'hA5, 7'd0,   1'b1, 7'd1, 11'd3},
        '{CMD_PRODUCE, 8'h5A, 7'd0,   1'b1, 7'd1, 11'd4},
        '{CMD_PEEK,    8'h00, 7'd0,   1'b1, 7'd0, 11'd4},
        '{CMD_PEEK,    8'h00, 7'd2,   1'b0, 7'd0, 11'd0},
        '{CMD_CONSUME, 8'h00, 7'd1,   1'b0, 7'd0, 11'd0},
        '{CMD_PEEK,    8'h00, 7'd127, 1'b0, 7'd0, 11'd0},
        '{CMD_DROP,    8'h00, 7'd1,   1'b1, 7'd1, 11'd2},
        '{CMD_CONSUME, 8'h00, 7'd64,  1'b0, 7'd0, 11'd0},
        '{CMD_CONSUME, 8'h00, 7'd3,   1'b1, 7'd0, 11'd0},
        '{CMD_PEEK,    8'h00, 7'd64,  1'b1, 7'd0, 11'd0},
        '{CMD_PRODUCE, 8'h80, 7'd0,   1'b1, 7'd1, 11'd1},
        '{CMD_PRODUCE, 8'h01, 7'd0,   1'b1, 7'd1, 11'd2},
        '{CMD_PRODUCE, 8'h7F, 7'd0,   1'b1, 7'd1, 11'd3},
        '{CMD_PRODUCE, 8'hFE, 7'd0,   1'b1, 7'd1, 11'd4},
        '{CMD_CONSUME, 8'h00, 7'd65,  1'b0, 7'd0, 11'd0},
        '{CMD_DROP,    8'h00, 7'd64,  1'b1, 7'd0, 11'd0},
        '{CMD_PRODUCE, 8'h3C, 7'd0,   1'b1, 7'd1, 11'd1},
        '{CMD_DROP,    8'h00, 7'd127, 1'b1, 7'd1, 11'd0}
    };

    byte_ring_buffer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .i_length      (i_length),
        .empty         (empty),
        .pop           (pop),
        .o_read_byte   (o_read_byte),
        .o_byte_valid  (o_byte_valid),
        .o_moved_count (o_moved_count),
        .o_fill_level  (o_fill_level),
        .o_last        (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [FILL_W-1:0] ring_fill();
        return FILL_W'(ring_wr - ring_rd);
    endfunction

    function automatic void ring_predict(t_cmd c, logic [BYTE_W-1:0] d, logic [LEN_W-1:0] l);
        logic [FILL_W-1:0] fill;
        int                n;
        t_result           r;
        fill   = ring_fill();
        r      = '0;
        r.last = 1'b1;
        if (c == CMD_PRODUCE) begin
            if (fill < CAPACITY) begin
                ring_store[ring_wr[IDX_W-1:0]] = d;
                ring_wr = ring_wr + 1'b1;
                r.moved = 7'd1;
            end
            r.fill = ring_fill();
            pending_beats.push_back(r);
            return;
        end
        n = (l > MAX_REQUEST) ? MAX_REQUEST : int'(l);
        if (n > fill) n = fill;
        r.moved = LEN_W'(n);
        if (c == CMD_DROP) begin
            ring_rd = ring_rd + PTR_W'(n);
            r.fill  = ring_fill();
            pending_beats.push_back(r);
            return;
        end
        if (n == 0) begin
            r.fill = fill;
            pending_beats.push_back(r);
            return;
        end
        r.byte_valid = 1'b1;
        r.fill = (c == CMD_CONSUME) ? fill - FILL_W'(n) : fill;
        for (int i = 0; i < n; i++) begin
            r.read_byte = ring_store[IDX_W'(ring_rd + i)];
            r.last      = (i == n - 1);
            pending_beats.push_back(r);
        end
        if (c == CMD_CONSUME) ring_rd = ring_rd + PTR_W'(n);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 100) begin
            $display("mismatch on %s: got %0d, expected %0d, cycle %0d", what, got, want, cycles);
        end
    endtask

    // One command beat: an optional idle burst, then hold push until full is low.
    task automatic send_cmd(t_cmd c, logic [BYTE_W-1:0] d, logic [LEN_W-1:0] l);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            repeat (gap) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
        end
        @(negedge i_clk);
        push        <= 1'b1;
        i_command   <= c;
        i_data_byte <= d;
        i_length    <= l;
        do @(posedge i_clk); while (full);
        ring_predict(c, d, l);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (quiet) begin
            pop <= 1'b1;
        end else if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            stall_left = $urandom_range(1, 15) - 1;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected result beat", o_read_byte, 0);
            end else begin
                want_beat = pending_beats.pop_front();
                if (o_read_byte !== want_beat.read_byte)
                    report_mismatch("read_byte", o_read_byte, want_beat.read_byte);
                if (o_byte_valid !== want_beat.byte_valid)
                    report_mismatch("byte_valid", o_byte_valid, want_beat.byte_valid);
                if (o_moved_count !== want_beat.moved)
                    report_mismatch("moved_count", o_moved_count, want_beat.moved);
                if (o_fill_level !== want_beat.fill)
                    report_mismatch("fill_level", o_fill_level, want_beat.fill);
                if (o_last !== want_beat.last)
                    report_mismatch("last", o_last, want_beat.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb_byte_ring_buffer_top failed");
            $finish;
        end
    end

    initial begin
        t_cmd             c;
        logic [LEN_W-1:0] l;
        int               w;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            send_cmd(dir_rows[k].cmd, dir_rows[k].data, dir_rows[k].len);
            if (dir_rows[k].typed) begin
                void'(pending_beats.pop_back());
                pending_beats.push_back(t_result'{read_byte: '0, byte_valid: 1'b0,
                    moved: dir_rows[k].moved, fill: dir_rows[k].fill, last: 1'b1});
            end
        end
        @(negedge i_clk);
        push <= 1'b0;
        wait_drained();

        for (int k = 0; k < 280; k++) begin
            if (k == 240) quiet = 1'b1;
            w = $urandom_range(0, 99);
            c = (w < 55) ? CMD_PRODUCE : (w < 72) ? CMD_CONSUME : (w < 86) ? CMD_PEEK : CMD_DROP;
            l = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 12));
            send_cmd(c, 8'($urandom), l);
        end
        @(negedge i_clk);
        push <= 1'b0;

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("tb_byte_ring_buffer_top passed");
        end else begin
            $display("tb_byte_ring_buffer_top failed");
        end
        $finish;
    end

endmodule
